FILE: hdl/vaew_pkg.sv
// Shared types, constants and table functions for the voice allocator envelope writer.
package vaew_pkg;

  // Voice count bounds
  localparam int MAX_VOICES     = 6;
  localparam int VOICES_DEFAULT = 6;

  // Event action codes
  localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [1:0] ACT_TICK     = 2'd2;

  // Configuration register indexes
  localparam logic [7:0] CFG_ATTACK  = 8'd0;
  localparam logic [7:0] CFG_DECAY   = 8'd1;
  localparam logic [7:0] CFG_RELEASE = 8'd2;

  // Configuration reset values
  localparam logic [7:0] ATTACK_RESET  = 8'd4;
  localparam logic [7:0] DECAY_RESET   = 8'd4;
  localparam logic [7:0] RELEASE_RESET = 8'd12;

  // Chip register map and envelope constants
  localparam logic [4:0] OCT_BASE   = 5'h10;
  localparam logic [4:0] FREQ_BASE  = 5'h08;
  localparam logic [3:0] VOL_MAX    = 4'd11;
  localparam logic [7:0] OCT_STEP   = 8'd12;
  localparam int         VEL_SHIFT  = 3;
  localparam logic [3:0] MAX_WRITES = 4'd12;
  localparam logic [3:0] ATK_STEPS  = 4'd4;
  localparam logic [3:0] ENV_STEPS  = 4'd8;

  // Reciprocal of twelve for values below 144: q = (n * 171) >> 11
  localparam logic [7:0] DIV12_MUL   = 8'd171;
  localparam int         DIV12_SHIFT = 11;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] pitch;
    logic [6:0] velocity;
  } event_t;

  typedef struct packed {
    logic [4:0] reg_address;
    logic [7:0] reg_data;
    logic       last_write;
  } write_t;

  // Command from the sequencer to the write buffer
  typedef struct packed {
    logic       push;
    logic       flush;
    logic [4:0] reg_address;
    logic [7:0] reg_data;
  } wcmd_t;

  // Frequency byte for a semitone within the octave
  function automatic logic [7:0] freq_byte(input logic [3:0] idx);
    logic [7:0] f;
    case (idx)
      4'd0:    f = 8'd5;
      4'd1:    f = 8'd32;
      4'd2:    f = 8'd60;
      4'd3:    f = 8'd85;
      4'd4:    f = 8'd110;
      4'd5:    f = 8'd132;
      4'd6:    f = 8'd153;
      4'd7:    f = 8'd173;
      4'd8:    f = 8'd192;
      4'd9:    f = 8'd210;
      4'd10:   f = 8'd227;
      4'd11:   f = 8'd243;
      default: f = 8'd0;
    endcase
    return f;
  endfunction

  // Volume byte: both nibbles carry the level, upper nibble ORs in the high bits
  function automatic logic [7:0] vol_byte(input logic [7:0] v);
    return {v[3:0] | v[7:4], v[3:0]};
  endfunction

endpackage

FILE: hdl/voice_allocator_envelope_writer.sv
// Top level: voice allocation and envelope sequencer driving chip register writes.
// Sequencing: a note-on starts up to two voices, a note-off checks every voice, and a tick
//   runs attack, decay and release for every voice; write_stall can hold each write phase.
// Throughput: one event at a time; the sequencer steps one phase per cycle while the write buffer can accept.
// Writes leave through an output register, one per cycle while write_stall is low, the last flagged.
// Reset (rst, synchronous): all voices idle and cleared, rates set to 4, 4 and 12.
module voice_allocator_envelope_writer
  import vaew_pkg::*;
#(
  parameter int VOICES = VOICES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       event_valid,
  output logic       event_stall,
  input  event_t     event_item,
  output logic       write_valid,
  input  logic       write_stall,
  output write_t     write_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int VIDX_W = $clog2(VOICES);
  localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICES - 1);

  // Sequencer state codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ON_PICK = 4'd1;
  localparam logic [3:0] S_ON_OCT  = 4'd2;
  localparam logic [3:0] S_ON_OCTW = 4'd3;
  localparam logic [3:0] S_ON_FREQ = 4'd4;
  localparam logic [3:0] S_ON_VOL  = 4'd5;
  localparam logic [3:0] S_OFF     = 4'd6;
  localparam logic [3:0] S_T_ATK   = 4'd7;
  localparam logic [3:0] S_T_DEC   = 4'd8;
  localparam logic [3:0] S_T_REL   = 4'd9;
  localparam logic [3:0] S_FINISH  = 4'd10;

  // Rate registers
  logic [7:0] attack_ticks;
  logic [7:0] decay_ticks;
  logic [7:0] release_ticks;

  // Per-voice state
  logic [VOICES-1:0] voice_active;
  logic [VOICES-1:0] key_held;
  logic [7:0]        voice_pitch     [VOICES];
  logic [7:0]        last_octave     [VOICES];
  logic [7:0]        voice_volume    [VOICES];
  logic [3:0]        envelope_step   [VOICES];
  logic [7:0]        ticks_since_on  [VOICES];
  logic [7:0]        ticks_since_off [VOICES];

  // Sequencer registers
  logic [3:0]        state;
  logic [VIDX_W-1:0] cur;
  logic              second;
  logic [3:0]        res_n;
  logic [6:0]        ev_pitch;
  logic [6:0]        ev_velocity;
  logic [7:0]        oct_r;
  logic [3:0]        fidx_r;

  // Combinational helpers
  logic              can_push;
  wcmd_t             cmd;
  logic              em_req;
  logic [4:0]        em_addr;
  logic [7:0]        em_data;
  logic              free_found;
  logic [VIDX_W-1:0] free_idx;
  logic [VIDX_W-1:0] pick_ch;
  logic [7:0]        note;
  logic [7:0]        note_n;
  logic [15:0]       div_prod;
  logic [3:0]        div_q;
  logic [7:0]        div_rem;
  logic [7:0]        oct_new;
  logic [VIDX_W-1:0] partner;
  logic [7:0]        partner_oct;
  logic [3:0]        vol_clamp;
  logic [7:0]        pitch_up;
  logic              cur_act;
  logic              cur_held;
  logic [7:0]        cur_vol;
  logic [3:0]        cur_step;
  logic [7:0]        ton_inc;
  logic [7:0]        toff_inc;
  logic [7:0]        vol_up;
  logic [7:0]        vol_dn;
  logic              atk_run;
  logic              dec_run;
  logic              rel_run;
  logic              atk_fire;
  logic              dec_fire;
  logic              rel_fire;

  assign event_stall = (state != S_IDLE);
  assign cfg_ready   = 1'b1;

  // Lowest idle voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!voice_active[i]) begin
        free_found = 1'b1;
        free_idx   = VIDX_W'(i);
      end
    end
  end

  // Voice choice and octave split for the next voice start
  assign pick_ch  = (second || free_found) ? free_idx : '0;
  assign pitch_up = {1'b0, ev_pitch} + OCT_STEP;
  assign note     = second ? pitch_up : {1'b0, ev_pitch};
  assign note_n   = note + 8'd1;
  assign div_prod = note_n * DIV12_MUL;
  assign div_q    = div_prod[DIV12_SHIFT+3:DIV12_SHIFT];
  assign div_rem  = note_n - ({4'd0, div_q} * OCT_STEP);
  assign oct_new  = {4'd0, div_q} - 8'd1;

  // Velocity to starting volume, clamped to 1..VOL_MAX
  always_comb begin
    vol_clamp = 4'(ev_velocity >> VEL_SHIFT);
    if (vol_clamp == 4'd0) begin
      vol_clamp = 4'd1;
    end else if (vol_clamp > VOL_MAX) begin
      vol_clamp = VOL_MAX;
    end
  end

  // Partner octave; a partner beyond the voice count reads as zero
  assign partner = cur ^ VIDX_W'(1);
  always_comb begin
    partner_oct = 8'd0;
    if ({1'b0, partner} < (VIDX_W + 1)'(VOICES)) begin
      partner_oct = last_octave[partner];
    end
  end

  // Current voice fields and envelope arithmetic
  assign cur_act  = voice_active[cur];
  assign cur_held = key_held[cur];
  assign cur_vol  = voice_volume[cur];
  assign cur_step = envelope_step[cur];
  assign ton_inc  = ticks_since_on[cur] + 8'd1;
  assign toff_inc = ticks_since_off[cur] + 8'd1;
  assign vol_up   = cur_vol + 8'd1;
  assign vol_dn   = cur_vol - 8'd1;
  assign atk_run  = cur_act && (cur_step < ATK_STEPS);
  assign dec_run  = cur_act && (cur_step >= ATK_STEPS) && (cur_step < ENV_STEPS);
  assign rel_run  = cur_act && !cur_held;
  assign atk_fire = atk_run && (ton_inc >= attack_ticks);
  assign dec_fire = dec_run && (ton_inc >= decay_ticks);
  assign rel_fire = rel_run && (toff_inc >= release_ticks);

  // Select the write produced in this phase
  always_comb begin
    em_req  = 1'b0;
    em_addr = 5'(cur);
    em_data = 8'd0;
    case (state)
      S_ON_OCTW: begin
        em_req  = 1'b1;
        em_addr = OCT_BASE + 5'(cur >> 1);
        if (!cur[0]) begin
          em_data = {oct_r[7:4] | partner_oct[3:0], oct_r[3:0]};
        end else begin
          em_data = {oct_r[3:0] | partner_oct[7:4], partner_oct[3:0]};
        end
      end
      S_ON_FREQ: begin
        em_req  = 1'b1;
        em_addr = FREQ_BASE + 5'(cur);
        em_data = freq_byte(fidx_r);
      end
      S_ON_VOL: begin
        em_req  = 1'b1;
        em_data = vol_byte({4'd0, vol_clamp});
      end
      S_T_ATK: begin
        em_req  = atk_fire;
        em_data = vol_byte(vol_up);
      end
      S_T_DEC: begin
        em_req  = dec_fire;
        em_data = vol_byte(vol_dn);
      end
      S_T_REL: begin
        em_req  = rel_fire;
        em_data = vol_byte(vol_dn);
      end
      default: begin
        em_req = 1'b0;
      end
    endcase
  end

  // Buffer command for this phase; drop writes past the per-event limit
  always_comb begin
    cmd             = '0;
    cmd.reg_address = em_addr;
    cmd.reg_data    = em_data;
    cmd.push        = em_req && can_push && (res_n < MAX_WRITES);
    cmd.flush       = (state == S_FINISH) && can_push;
  end

  // Rate register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ticks  <= ATTACK_RESET;
      decay_ticks   <= DECAY_RESET;
      release_ticks <= RELEASE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ATTACK:  attack_ticks  <= cfg_data;
        CFG_DECAY:   decay_ticks   <= cfg_data;
        CFG_RELEASE: release_ticks <= cfg_data;
        default:     attack_ticks  <= attack_ticks;
      endcase
    end
  end

  // Sequencer and voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cur          <= '0;
      second       <= 1'b0;
      res_n        <= 4'd0;
      voice_active <= '0;
      key_held     <= '0;
      for (int i = 0; i < VOICES; i++) begin
        voice_pitch[i]     <= 8'd0;
        last_octave[i]     <= 8'd0;
        voice_volume[i]    <= 8'd0;
        envelope_step[i]   <= 4'd0;
        ticks_since_on[i]  <= 8'd0;
        ticks_since_off[i] <= 8'd0;
      end
    end else begin
      if (cmd.push) begin
        res_n <= res_n + 4'd1;
      end
      case (state)
        S_IDLE: begin
          if (event_valid) begin
            ev_pitch    <= event_item.pitch;
            ev_velocity <= event_item.velocity;
            res_n       <= 4'd0;
            second      <= 1'b0;
            cur         <= '0;
            case (event_item.action)
              ACT_NOTE_ON:  state <= S_ON_PICK;
              ACT_NOTE_OFF: state <= S_OFF;
              ACT_TICK:     state <= S_T_ATK;
              default:      state <= S_FINISH;
            endcase
          end
        end
        S_ON_PICK: begin
          if (second && !free_found) begin
            state <= S_FINISH;
          end else begin
            cur                  <= pick_ch;
            voice_active[pick_ch] <= 1'b1;
            key_held[pick_ch]     <= 1'b1;
            voice_pitch[pick_ch]  <= note;
            oct_r                <= oct_new;
            fidx_r               <= div_rem[3:0];
            state                <= S_ON_OCT;
          end
        end
        S_ON_OCT: begin
          if (last_octave[cur] != oct_r) begin
            last_octave[cur] <= oct_r;
            state            <= S_ON_OCTW;
          end else begin
            state <= S_ON_FREQ;
          end
        end
        S_ON_OCTW: begin
          if (can_push) begin
            state <= S_ON_FREQ;
          end
        end
        S_ON_FREQ: begin
          if (can_push) begin
            state <= S_ON_VOL;
          end
        end
        S_ON_VOL: begin
          if (can_push) begin
            voice_volume[cur]    <= {4'd0, vol_clamp};
            ticks_since_on[cur]  <= 8'd0;
            ticks_since_off[cur] <= 8'd0;
            if (!second) begin
              second <= 1'b1;
              state  <= S_ON_PICK;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_OFF: begin
          if (cur_held && (voice_pitch[cur] == {1'b0, ev_pitch} ||
                           voice_pitch[cur] == pitch_up)) begin
            key_held[cur] <= 1'b0;
          end
          if (cur == LAST_VOICE) begin
            state <= S_FINISH;
          end else begin
            cur <= cur + VIDX_W'(1);
          end
        end
        S_T_ATK: begin
          if (can_push) begin
            if (atk_run) begin
              ticks_since_on[cur] <= atk_fire ? 8'd0 : ton_inc;
            end
            if (atk_fire) begin
              voice_volume[cur]  <= vol_up;
              envelope_step[cur] <= cur_step + 4'd1;
            end
            state <= S_T_DEC;
          end
        end
        S_T_DEC: begin
          if (can_push) begin
            if (dec_run) begin
              ticks_since_on[cur] <= dec_fire ? 8'd0 : ton_inc;
            end
            if (dec_fire) begin
              voice_volume[cur]  <= vol_dn;
              envelope_step[cur] <= cur_step + 4'd1;
            end
            state <= S_T_REL;
          end
        end
        S_T_REL: begin
          if (can_push) begin
            if (rel_run) begin
              ticks_since_off[cur] <= rel_fire ? 8'd0 : toff_inc;
            end
            if (rel_fire) begin
              voice_volume[cur] <= vol_dn;
              if (vol_dn == 8'd0) begin
                voice_active[cur]  <= 1'b0;
                envelope_step[cur] <= 4'd0;
              end
            end
            if (cur == LAST_VOICE) begin
              state <= S_FINISH;
            end else begin
              cur   <= cur + VIDX_W'(1);
              state <= S_T_ATK;
            end
          end
        end
        S_FINISH: begin
          if (can_push) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  vaew_write_buffer u_write_buffer (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .can_accept  (can_push),
    .write_valid (write_valid),
    .write_stall (write_stall),
    .write_item  (write_item)
  );

  // Write count per event stays within the limit
  assert property (@(posedge clk) disable iff (rst) res_n <= MAX_WRITES)
    else $error("write count above limit");

  // Never push or flush into a full buffer
  assert property (@(posedge clk) disable iff (rst)
    (cmd.push || cmd.flush) |-> can_push)
    else $error("buffer overrun");

  // Push and flush are exclusive
  assert property (@(posedge clk) disable iff (rst) !(cmd.push && cmd.flush))
    else $error("push and flush together");

  // An accepted event keeps the block busy on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (event_valid && !event_stall) |=> event_stall)
    else $error("event accepted without going busy");

endmodule

FILE: hdl/vaew_write_buffer.sv
// Pending-write holder and output register that marks the last write of each event.
module vaew_write_buffer
  import vaew_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  wcmd_t  cmd,
  output logic   can_accept,
  output logic   write_valid,
  input  logic   write_stall,
  output write_t write_item
);

  logic       pend_valid;
  logic [4:0] pend_address;
  logic [7:0] pend_data;
  logic       out_free;
  logic       load_out;

  assign out_free   = !write_valid || !write_stall;
  assign can_accept = !pend_valid || out_free;
  assign load_out   = (cmd.push || cmd.flush) && pend_valid;

  // Hold the newest write until the next one or the end of the event decides its last flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid  <= 1'b0;
      write_valid <= 1'b0;
    end else begin
      if (load_out) begin
        write_valid <= 1'b1;
      end else if (!write_stall) begin
        write_valid <= 1'b0;
      end
      if (cmd.push) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Payload: move pending to output, load new pending
  always_ff @(posedge clk) begin
    if (load_out) begin
      write_item.reg_address <= pend_address;
      write_item.reg_data    <= pend_data;
      write_item.last_write  <= cmd.flush;
    end
    if (cmd.push) begin
      pend_address <= cmd.reg_address;
      pend_data    <= cmd.reg_data;
    end
  end

endmodule
